// ===== design/mwsp_pkg.sv =====
// Package for the minimum-weight simple path search block.
// Holds opcode codes, register indexes and the path total width; no dependencies.
package mwsp_pkg;
    localparam int TotalBits = 20;
    localparam logic [TotalBits-1:0] TotalMax = {TotalBits{1'b1}};
    localparam logic [1:0] OpAdd    = 2'd0;
    localparam logic [1:0] OpSearch = 2'd1;
    localparam logic [1:0] OpClear  = 2'd2;
    localparam logic [1:0] RegNodeCount = 2'd0;
    localparam logic [1:0] RegStart     = 2'd1;
    localparam logic [1:0] RegTarget    = 2'd2;
endpackage

// ===== design/mwsp_edge_mem.sv =====
// Edge store: presence bits with a clearing pass and a length memory.
// Depends on mwsp_pkg.
module mwsp_edge_mem
    import mwsp_pkg::*;
#(
    parameter int NODES       = 16,
    parameter int WEIGHT_BITS = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_wr,
    input  logic [2*$clog2(NODES)-1:0]           i_wr_addr,
    input  logic [WEIGHT_BITS-1:0]               i_wr_len,
    input  logic                                 i_clr_start,
    output logic                                 o_clr_busy,
    input  logic [2*$clog2(NODES)-1:0]           i_rd_addr,
    output logic                                 o_rd_present,
    output logic [WEIGHT_BITS-1:0]               o_rd_len
);
    localparam int AW    = 2 * $clog2(NODES);
    localparam int Depth = 2 ** AW;

    logic                   r_present [Depth];
    logic [WEIGHT_BITS-1:0] r_len     [Depth];
    logic                   r_busy;
    logic [AW-1:0]          r_clr_addr;

    assign o_clr_busy = r_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy     <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_busy) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (r_clr_addr == AW'(Depth - 1)) begin
                r_busy <= 1'b0;
            end
        end else if (i_clr_start) begin
            r_busy     <= 1'b1;
            r_clr_addr <= '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_busy) begin
            r_present[r_clr_addr] <= 1'b0;
        end else if (i_wr) begin
            r_present[i_wr_addr] <= 1'b1;
        end
        o_rd_present <= r_present[i_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_wr && !r_busy) begin
            r_len[i_wr_addr] <= i_wr_len;
        end
        o_rd_len <= r_len[i_rd_addr];
    end
endmodule

// ===== design/mwsp_search.sv =====
// Depth-first search sequencer with an explicit stack and one shared
// saturating adder/compare. Depends on mwsp_pkg.
module mwsp_search
    import mwsp_pkg::*;
#(
    parameter int NODES       = 16,
    parameter int WEIGHT_BITS = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_go,
    input  logic [5:0]                      i_cnt,
    input  logic [4:0]                      i_start,
    input  logic [4:0]                      i_target,
    output logic [2*$clog2(NODES)-1:0]      o_rd_addr,
    input  logic                            i_rd_present,
    input  logic [WEIGHT_BITS-1:0]          i_rd_len,
    output logic                            o_done,
    output logic                            o_found,
    output logic [TotalBits-1:0]            o_total,
    output logic [NODES-1:0]                o_mask
);
    localparam int NB = $clog2(NODES);
    localparam int DB = $clog2(NODES + 1);

    typedef enum logic [2:0] {S_IDLE, S_STEP, S_READ, S_EVAL, S_DONE} t_state;

    t_state                r_state;
    logic [NB-1:0]         r_snode [NODES+1];
    logic [5:0]            r_snext [NODES+1];
    logic [TotalBits-1:0]  r_stot  [NODES+1];
    logic [DB-1:0]         r_d;
    logic [NODES-1:0]      r_vis;
    logic [NB-1:0]         r_i;
    logic                  r_found;
    logic [TotalBits-1:0]  r_best;
    logic [NODES-1:0]      r_bmask;

    logic [NB-1:0]         w_top;
    logic [5:0]            w_nx;
    logic [TotalBits-1:0]  w_cur;
    logic [TotalBits:0]    w_sum;
    logic [TotalBits-1:0]  w_t;
    logic                  w_start_ok;

    assign w_top = r_snode[r_d];
    assign w_nx  = r_snext[r_d];
    assign w_cur = r_stot[r_d];
    assign w_sum = {1'b0, w_cur} + (TotalBits + 1)'(i_rd_len);
    assign w_t   = w_sum[TotalBits] ? TotalMax : w_sum[TotalBits-1:0];
    assign w_start_ok = (i_start != 5'd0) && ({1'b0, i_start} <= i_cnt);
    assign o_rd_addr = {w_top, r_i};
    assign o_done  = (r_state == S_DONE);
    assign o_found = r_found;
    assign o_total = r_best;
    assign o_mask  = r_bmask;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_found <= 1'b0;
            r_best  <= TotalMax;
            r_bmask <= '0;
            r_vis   <= '0;
            r_d     <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_go) begin
                        r_found <= 1'b0;
                        r_best  <= TotalMax;
                        r_bmask <= '0;
                        r_vis   <= '0;
                        r_d     <= '0;
                        if (!w_start_ok) begin
                            r_state <= S_DONE;
                        end else if (i_start == i_target) begin
                            r_found <= 1'b1;
                            r_best  <= '0;
                            r_bmask <= NODES'(1) << (i_start - 5'd1);
                            r_state <= S_DONE;
                        end else begin
                            r_vis <= NODES'(1) << (i_start - 5'd1);
                            r_snode[0] <= NB'(i_start - 5'd1);
                            r_snext[0] <= 6'd1;
                            r_stot[0]  <= '0;
                            r_state <= S_STEP;
                        end
                    end
                end
                S_STEP: begin
                    if (w_nx > i_cnt) begin
                        if (r_d == '0) begin
                            r_vis   <= '0;
                            r_state <= S_DONE;
                        end else begin
                            r_vis[w_top] <= 1'b0;
                            r_d <= r_d - 1'b1;
                        end
                    end else begin
                        r_snext[r_d] <= w_nx + 6'd1;
                        r_i <= NB'(w_nx - 6'd1);
                        if (!r_vis[NB'(w_nx - 6'd1)]) begin
                            r_state <= S_READ;
                        end
                    end
                end
                S_READ: r_state <= S_EVAL;
                S_EVAL: begin
                    r_state <= S_STEP;
                    if (i_rd_present) begin
                        if ({1'b0, r_i} + 6'd1 == {1'b0, i_target}) begin
                            if (!r_found || w_t < r_best) begin
                                r_found <= 1'b1;
                                r_best  <= w_t;
                                r_bmask <= r_vis | (NODES'(1) << r_i);
                            end
                        end else if (32'(r_d) + 1 <= NODES) begin
                            r_vis[r_i] <= 1'b1;
                            r_d <= r_d + 1'b1;
                            r_snode[r_d + 1'b1] <= r_i;
                            r_snext[r_d + 1'b1] <= 6'd1;
                            r_stot[r_d + 1'b1]  <= w_t;
                        end
                    end
                end
                S_DONE: r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

// ===== design/min_weight_simple_path_search.sv =====
// Top level of the minimum-weight simple path search block.
// Depends on mwsp_pkg, mwsp_edge_mem and mwsp_search.
//
//   channel | valid    | stall    | payload
//   input   | i_valid  | o_stall  | i_opcode i_from_node i_to_node i_weight
//   output  | o_valid  | i_stall  | o_path_found o_best_total o_best_path_mask
//
// Add and unknown opcodes raise no busy state; clear runs a one-bit-per-cycle pass
// over the presence bits, and the same pass follows reset. A search takes each
// unvisited neighbour through pick, edge read and evaluate, skips a visited one at
// the pick, backtracks when a node's neighbours run out, and then finishes.
// After a search is accepted, the block stalls input until its result beat is taken.
module min_weight_simple_path_search
    import mwsp_pkg::*;
#(
    parameter int NODES       = 16,
    parameter int WEIGHT_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [4:0]  i_cfg_data,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_opcode,
    input  logic [4:0]  i_from_node,
    input  logic [4:0]  i_to_node,
    input  logic [15:0] i_weight,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_path_found,
    output logic [19:0] o_best_total,
    output logic [15:0] o_best_path_mask
);
    localparam int NB = $clog2(NODES);
    localparam int AW = 2 * NB;

    logic [4:0] r_node_count, r_start, r_target;
    logic       r_busy;
    logic       w_accept, w_go, w_clr, w_wr, w_clr_busy, w_rd_present, w_done;
    logic       w_found;
    logic [AW-1:0] w_rd_addr, w_wr_addr;
    logic [WEIGHT_BITS-1:0] w_rd_len, w_len;
    logic [TotalBits-1:0] w_total;
    logic [NODES-1:0] w_mask;
    logic [5:0] w_cnt;

    assign o_stall  = r_busy || o_valid || w_clr_busy;
    assign w_accept = i_valid && !o_stall;
    assign w_go  = w_accept && (i_opcode == OpSearch);
    assign w_clr = w_accept && (i_opcode == OpClear);
    assign w_wr  = w_accept && (i_opcode == OpAdd) && (i_from_node != 5'd0)
                   && (i_to_node != 5'd0) && (32'(i_from_node) <= NODES)
                   && (32'(i_to_node) <= NODES);
    assign w_wr_addr = {NB'(i_from_node - 5'd1), NB'(i_to_node - 5'd1)};
    assign w_len = WEIGHT_BITS'(i_weight);
    assign w_cnt = (32'(r_node_count) > NODES) ? 6'(NODES) : {1'b0, r_node_count};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_count <= 5'd16;
            r_start      <= 5'd1;
            r_target     <= 5'd5;
            r_busy       <= 1'b0;
            o_valid      <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    RegNodeCount: r_node_count <= i_cfg_data;
                    RegStart:     r_start      <= i_cfg_data;
                    RegTarget:    r_target     <= i_cfg_data;
                    default: ;
                endcase
            end
            if (w_go) begin
                r_busy <= 1'b1;
            end
            if (w_done) begin
                r_busy           <= 1'b0;
                o_valid          <= 1'b1;
                o_path_found     <= w_found;
                o_best_total     <= w_total;
                o_best_path_mask <= 16'(w_mask);
            end else if (o_valid && !i_stall) begin
                o_valid <= 1'b0;
            end
        end
    end

    mwsp_edge_mem #(.NODES(NODES), .WEIGHT_BITS(WEIGHT_BITS)) u_mem (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_wr(w_wr), .i_wr_addr(w_wr_addr), .i_wr_len(w_len),
        .i_clr_start(w_clr), .o_clr_busy(w_clr_busy),
        .i_rd_addr(w_rd_addr), .o_rd_present(w_rd_present), .o_rd_len(w_rd_len)
    );

    mwsp_search #(.NODES(NODES), .WEIGHT_BITS(WEIGHT_BITS)) u_search (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_go(w_go),
        .i_cnt(w_cnt), .i_start(r_start), .i_target(r_target),
        .o_rd_addr(w_rd_addr), .i_rd_present(w_rd_present), .i_rd_len(w_rd_len),
        .o_done(w_done), .o_found(w_found), .o_total(w_total), .o_mask(w_mask)
    );
endmodule
